// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lgfr_pkg.sv =====
`timescale 1ns / 1ps
package lgfr_pkg;

    // Grid geometry
    localparam int GRID       = 8;
    localparam int ROW_STRIDE = 8;
    localparam int INNER      = GRID - 2;
    localparam int FRAME_W    = 64;
    localparam int LEVEL_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int STYLE_W    = 2;

    // Scaled count: up to INNER*INNER dots
    localparam int Q_W   = $clog2(INNER * INNER + 1);
    localparam int NUM_W = LEVEL_W + Q_W;
    localparam int DSH_W = LEVEL_W + Q_W - 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STYLE      = 2'd2;

    // Display styles
    localparam logic [STYLE_W-1:0] STYLE_WARN_ONLY = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_DOTS      = 2'd3;

    // Reset values of the range registers
    localparam logic signed [LEVEL_W-1:0] RANGE_LOW_RST  = 16'sd0;
    localparam logic signed [LEVEL_W-1:0] RANGE_HIGH_RST = 16'sd1000;

    typedef struct packed {
        logic start;
        logic dots;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Border plus interior for one frame that is not blank.
    function automatic logic [FRAME_W-1:0] render_frame(
        input logic               warn,
        input logic               dots,
        input logic [PHASE_W-1:0] phase,
        input logic [Q_W-1:0]     count
    );
        logic [FRAME_W-1:0] f;
        logic [PHASE_W:0]   y;
        logic               show;
        int                 prior;
        int                 k;
        f = '0;
        // left and right columns, bottom row
        for (int r = 0; r < GRID - 1; r++) begin
            f[r*ROW_STRIDE]            = 1'b1;
            f[r*ROW_STRIDE + GRID - 1] = 1'b1;
        end
        for (int c = 0; c < GRID; c++) begin
            f[(GRID-1)*ROW_STRIDE + c] = 1'b1;
        end
        show = 1'b1;
        // falling block while warned
        if (warn) begin
            y = {1'b0, phase} + 1'b1;
            for (int r = 1; r <= GRID - 2; r++) begin
                if (r >= int'(y)) begin
                    for (int c = 1; c <= INNER; c++) begin
                        f[r*ROW_STRIDE + c] = 1'b1;
                    end
                end
            end
            show = dots && (int'(y) >= GRID - 1);
        end
        if (show) begin
            if (!dots) begin
                // whole rows from the bottom
                for (int r = 1; r <= GRID - 2; r++) begin
                    if (int'(count) >= GRID - 1 - r) begin
                        for (int c = 1; c <= INNER; c++) begin
                            f[r*ROW_STRIDE + c] = 1'b1;
                        end
                    end
                end
            end else begin
                // dots row by row from the bottom, each row from the left
                for (int r = 1; r <= GRID - 2; r++) begin
                    prior = (GRID - 2 - r) * INNER;
                    k = int'(count) - prior;
                    for (int c = 1; c <= INNER; c++) begin
                        if (c <= k) begin
                            f[r*ROW_STRIDE + c] = 1'b1;
                        end
                    end
                end
            end
        end
        return f;
    endfunction

endpackage

// ===== rtl/lgfr_div.sv =====
`timescale 1ns / 1ps
// Clamp, scale and restoring division of the level, one quotient bit a cycle.
module lgfr_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lgfr_pkg::div_req_t                   req,
    input  logic signed [lgfr_pkg::LEVEL_W-1:0]  level,
    input  logic signed [lgfr_pkg::LEVEL_W-1:0]  range_low,
    input  logic signed [lgfr_pkg::LEVEL_W-1:0]  range_high,
    output lgfr_pkg::div_stat_t                  stat,
    output logic [lgfr_pkg::Q_W-1:0]             quotient
);

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_CLAMP = 3'd1;
    localparam logic [2:0] D_SCALE = 3'd2;
    localparam logic [2:0] D_DIV   = 3'd3;
    localparam logic [2:0] D_DONE  = 3'd4;
    localparam int STEP_W = $clog2(lgfr_pkg::Q_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(lgfr_pkg::Q_W - 1);

    logic [2:0] state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic dots_reg, dots_next;
    logic ok_reg, ok_next;
    logic signed [lgfr_pkg::LEVEL_W-1:0] v_reg, v_next;
    logic [lgfr_pkg::LEVEL_W-1:0] den_reg, den_next;
    logic [lgfr_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [lgfr_pkg::DSH_W-1:0] dsh_reg, dsh_next;
    logic [lgfr_pkg::Q_W-1:0] q_reg, q_next;

    logic signed [lgfr_pkg::LEVEL_W:0] span;
    logic signed [lgfr_pkg::LEVEL_W:0] diff_s;
    logic [lgfr_pkg::LEVEL_W-1:0] diff;
    logic [lgfr_pkg::NUM_W-1:0] num;
    logic [lgfr_pkg::NUM_W:0] trial;

    // Datapath: range span, offset from range_low, scaled numerator, trial subtract
    always_comb begin
        span   = {range_high[lgfr_pkg::LEVEL_W-1], range_high}
               - {range_low[lgfr_pkg::LEVEL_W-1], range_low};
        diff_s = {v_reg[lgfr_pkg::LEVEL_W-1], v_reg}
               - {range_low[lgfr_pkg::LEVEL_W-1], range_low};
        diff   = diff_s[lgfr_pkg::LEVEL_W-1:0];
        // times 36 for dots, times 6 for bars
        if (dots_reg) begin
            num = ({{(lgfr_pkg::Q_W){1'b0}}, diff} << 5)
                + ({{(lgfr_pkg::Q_W){1'b0}}, diff} << 2);
        end else begin
            num = ({{(lgfr_pkg::Q_W){1'b0}}, diff} << 2)
                + ({{(lgfr_pkg::Q_W){1'b0}}, diff} << 1);
        end
        trial = {1'b0, rem_reg} - {2'b00, dsh_reg};
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        dots_next  = dots_reg;
        ok_next    = ok_reg;
        v_next     = v_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        unique case (state_reg)
            D_IDLE, D_DONE: begin
                if (req.start) begin
                    dots_next  = req.dots;
                    state_next = D_CLAMP;
                end
            end
            D_CLAMP: begin
                ok_next  = range_high > range_low;
                den_next = span[lgfr_pkg::LEVEL_W-1:0];
                priority if (level < range_low) begin
                    v_next = range_low;
                end else if (level > range_high) begin
                    v_next = range_high;
                end else begin
                    v_next = level;
                end
                state_next = D_SCALE;
            end
            D_SCALE: begin
                rem_next   = ok_reg ? num : '0;
                dsh_next   = {den_reg, {(lgfr_pkg::Q_W-1){1'b0}}};
                q_next     = '0;
                step_next  = '0;
                state_next = D_DIV;
            end
            D_DIV: begin
                if (!trial[lgfr_pkg::NUM_W]) begin
                    rem_next = trial[lgfr_pkg::NUM_W-1:0];
                end
                q_next    = {q_reg[lgfr_pkg::Q_W-2:0], ~trial[lgfr_pkg::NUM_W]};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = D_DONE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg <= step_next;
        dots_reg <= dots_next;
        ok_reg   <= ok_next;
        v_reg    <= v_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
    end

    assign stat.done = (state_reg == D_DONE);
    assign stat.busy = (state_reg != D_IDLE) && (state_reg != D_DONE);
    // empty or inverted range scales to zero
    assign quotient  = ok_reg ? q_reg : '0;

endmodule

// ===== rtl/level_gauge_frame_render.sv =====
`timescale 1ns / 1ps
// Level gauge frame renderer: one 8x8 gauge frame per level sample.
// Input stream s_*: tdata carries the signed 16-bit level, tuser the blank
// and warn flags. Output stream m_*: tdata carries the 64-bit frame, pixel
// (row, column) at bit row*8+column. cfg_* writes range_low (index 0),
// range_high (index 1) and display_style (index 2); it is always ready.
// Each sample passes the clamp, the scaling and the 6-step restoring division
// of the divider, and its frame is then written to the output register and
// shown on m_tvalid. After a sample is taken s_tready stays low until its
// frame is written, so only one sample is in the block at a time.
// The result sits in an output register, so a new sample is taken while an
// earlier frame still waits. If the receiver stalls, a finished frame waits
// in the divider until the output register frees up, and s_tready stays low.
// Reset (aresetn low, synchronous) clears the blink phase, loads the range
// registers with 0 and 1000 and the style with bars, and empties the output.
module level_gauge_frame_render (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] level
    input  logic [1:0]                        s_tuser,   // [0] blank, [1] warn
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lgfr_pkg::FRAME_W-1:0]      m_tdata,   // [63:0] frame
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lgfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;
    localparam logic [lgfr_pkg::PHASE_W-1:0] PHASE_LAST =
        lgfr_pkg::PHASE_W'(lgfr_pkg::GRID - 1);

    logic state_reg, state_next;
    logic signed [lgfr_pkg::LEVEL_W-1:0] range_low_reg, range_high_reg;
    logic [lgfr_pkg::STYLE_W-1:0] style_reg;
    logic [lgfr_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic signed [lgfr_pkg::LEVEL_W-1:0] level_reg;
    logic blank_reg, warn_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic [lgfr_pkg::FRAME_W-1:0] m_tdata_reg, m_tdata_next;

    logic s_accept;
    logic out_free;
    logic zero_frame;
    lgfr_pkg::div_req_t div_req;
    lgfr_pkg::div_stat_t div_stat;
    logic [lgfr_pkg::Q_W-1:0] quotient;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign div_req.start = s_accept;
    assign div_req.dots  = (style_reg == lgfr_pkg::STYLE_DOTS);

    lgfr_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (div_req),
        .level      (level_reg),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .stat       (div_stat),
        .quotient   (quotient)
    );

    // Blink phase advances on every warned sample that is not blanked
    always_comb begin
        phase_next = phase_reg;
        if (s_accept && s_tuser[1] && !s_tuser[0]) begin
            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
        end
    end

    assign zero_frame = blank_reg
                     || ((style_reg == lgfr_pkg::STYLE_WARN_ONLY) && !warn_reg);

    // Control and output register
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_stat.done && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = zero_frame ? '0
                        : lgfr_pkg::render_frame(warn_reg, div_req.dots,
                                                 phase_reg, quotient);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            phase_reg      <= '0;
            range_low_reg  <= lgfr_pkg::RANGE_LOW_RST;
            range_high_reg <= lgfr_pkg::RANGE_HIGH_RST;
            style_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            phase_reg    <= phase_next;
            // configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    lgfr_pkg::CFG_RANGE_LOW:  range_low_reg  <= cfg_data;
                    lgfr_pkg::CFG_RANGE_HIGH: range_high_reg <= cfg_data;
                    lgfr_pkg::CFG_STYLE:
                        style_reg <= cfg_data[lgfr_pkg::STYLE_W-1:0];
                    default: ;
                endcase
            end
        end
        m_tdata_reg <= m_tdata_next;
        if (s_accept) begin
            level_reg <= s_tdata;
            blank_reg <= s_tuser[0];
            warn_reg  <= s_tuser[1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/lgfr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks for the gauge renderer.
module lgfr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lgfr_pkg::FRAME_W-1:0]  m_tdata
);

    logic s_take;
    logic lit_frame;
    logic border_ok;

    assign s_take    = s_tvalid && s_tready;
    assign lit_frame = m_tvalid && (m_tdata != '0);
    // top corners and bottom row lit, top row interior dark
    assign border_ok = m_tdata[0] && m_tdata[7] && (m_tdata[63:56] == 8'hFF)
                    && (m_tdata[6:1] == 6'h00);

    // output is empty right after reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // one sample at a time: busy in the cycle after a transaction
    `ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_take, !s_tready)

    // a frame that is not blank has its top corners, its bottom row and a dark top interior
    `ASSERT_IMPLIES(a_border, aclk, aresetn, lit_frame, border_ok)

    // stalled result holds
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind level_gauge_frame_render lgfr_checker u_lgfr_checker (.*);
